[rtl/core/csrf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the clip stack rectangle fill block.
// No dependencies; imported by every module under rtl/core.
package csrf_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int SLOTS       = STACK_DEPTH - 1;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 30;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE    = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        logic [31:0]        fill_colour;
    } cmd_t;

    typedef struct packed {
        logic [15:0]        top_x;
        logic [15:0]        top_y;
        logic [15:0]        top_width;
        logic [15:0]        top_height;
        logic [LEVEL_W-1:0] stack_level;
        logic               ignored;
        logic               fill_present;
        logic [31:0]        fill_address;
        logic [15:0]        fill_columns;
        logic [15:0]        fill_rows;
        logic [31:0]        fill_value;
    } rsp_t;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [17:0] row_pitch_bytes;
        logic [29:0] frame_base;
    } cfg_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } clip_t;

    typedef struct packed {
        clip_t              top;
        logic [LEVEL_W-1:0] level;
        logic               ignored;
    } stack_after_t;

endpackage

[rtl/core/clip_stack_rect_fill.sv]
`timescale 1ns / 1ps
// Clip rectangle stack with clipped fill: top level.
// An accepted request is held in the request register, and its result is written
// to the result register, from which it is taken.
// Throughput: one request per cycle unless the result side stalls; the clip
// intersection, stack update and address multiply fit between those two registers.
// Reset: stack back to the full-screen base, config registers to their defaults,
// both pipeline registers empty. The clip store is not cleared.
module clip_stack_rect_fill
    import csrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  cmd_t                   cmd,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp
);

    cfg_t         cfg;
    logic         cmd_valid_reg;
    cmd_t         cmd_reg;
    logic         rsp_valid_reg;
    rsp_t         rsp_reg;
    rsp_t         rsp_next;
    logic         advance;
    logic         stack_step;
    clip_t        cur_top;
    clip_t        cut_clip;
    stack_after_t after;
    logic [15:0]  stride;
    logic [31:0]  row_offset;
    logic [31:0]  fill_addr;
    logic         fill_hit;

    csrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Result register frees up when empty or when its request is taken.
    assign advance    = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall  = cmd_valid_reg && !advance;
    assign stack_step = cmd_valid_reg && advance;

    // Request register: hold while the result side is blocked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (!cmd_stall)
            cmd_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_reg <= cmd;
    end

    // Intersect the request rectangle with the current top clip, per axis.
    csrf_axis u_axis_x (
        .start     (cmd_reg.rect_x),
        .span      (cmd_reg.rect_width),
        .clip_lo   (cur_top.x),
        .clip_span (cur_top.w),
        .lo        (cut_clip.x),
        .len       (cut_clip.w)
    );

    csrf_axis u_axis_y (
        .start     (cmd_reg.rect_y),
        .span      (cmd_reg.rect_height),
        .clip_lo   (cur_top.y),
        .clip_span (cur_top.h),
        .lo        (cut_clip.y),
        .len       (cut_clip.h)
    );

    csrf_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (stack_step),
        .op       (cmd_reg.op),
        .cut_clip (cut_clip),
        .cfg      (cfg),
        .cur_top  (cur_top),
        .after    (after)
    );

    // Fill address: base + row * (pitch / 4) + column, wrapping at 32 bits.
    always_comb
    begin
        stride     = cfg.row_pitch_bytes[17:2];
        row_offset = {16'd0, cut_clip.y} * {16'd0, stride};
        fill_addr  = row_offset + {2'b00, cfg.frame_base} + {16'd0, cut_clip.x};
        fill_hit   = (cmd_reg.op == OP_FILL) && (cut_clip.w != 16'd0)
                     && (cut_clip.h != 16'd0);

        rsp_next.top_x        = after.top.x;
        rsp_next.top_y        = after.top.y;
        rsp_next.top_width    = after.top.w;
        rsp_next.top_height   = after.top.h;
        rsp_next.stack_level  = after.level;
        rsp_next.ignored      = after.ignored;
        rsp_next.fill_present = fill_hit;
        rsp_next.fill_address = fill_hit ? fill_addr : 32'd0;
        rsp_next.fill_columns = fill_hit ? cut_clip.w : 16'd0;
        rsp_next.fill_rows    = fill_hit ? cut_clip.h : 16'd0;
        rsp_next.fill_value   = fill_hit ? cmd_reg.fill_colour : 32'd0;
    end

    // Result register: advance when free, hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stack_step)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Every stack step lands in the result register on the next edge.
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        stack_step |=> rsp_valid)
        else $error("stack step did not produce a result");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.stack_level != LEVEL_W'(0))
                      && (rsp.stack_level <= LEVEL_W'(STACK_DEPTH)))
        else $error("stack level out of range");

    a_ignored_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.ignored && rsp.fill_present))
        else $error("ignored request reported a fill");

    a_fill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.fill_present) |->
            (rsp.fill_columns != 16'd0) && (rsp.fill_rows != 16'd0))
        else $error("fill reported with an empty area");

endmodule

[rtl/core/csrf_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file: screen size, row pitch and frame base.
// Depends on csrf_pkg.
module csrf_cfg
    import csrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= 16'd640;
            cfg_reg.screen_height   <= 16'd480;
            cfg_reg.row_pitch_bytes <= 18'd2560;
            cfg_reg.frame_base      <= 30'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width    <= cfg_data[15:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height   <= cfg_data[15:0];
                REG_ROW_PITCH:     cfg_reg.row_pitch_bytes <= cfg_data[17:0];
                REG_FRAME_BASE:    cfg_reg.frame_base      <= cfg_data[29:0];
                default:           cfg_reg.frame_base      <= cfg_reg.frame_base;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/csrf_axis.sv]
`timescale 1ns / 1ps
// One-axis intersection of a signed span against an unsigned clip span.
// Depends on csrf_pkg.
module csrf_axis
    import csrf_pkg::*;
(
    input  logic signed [15:0] start,
    input  logic [15:0]        span,
    input  logic [15:0]        clip_lo,
    input  logic [15:0]        clip_span,
    output logic [15:0]        lo,
    output logic [15:0]        len
);

    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] s;
    logic signed [17:0] ea;
    logic signed [17:0] eb;
    logic signed [17:0] e;
    logic signed [17:0] diff;

    always_comb
    begin
        a    = {{2{start[15]}}, start};
        b    = {2'b00, clip_lo};
        ea   = a + {2'b00, span};
        eb   = b + {2'b00, clip_span};
        s    = (a > b) ? a : b;
        e    = (ea < eb) ? ea : eb;
        diff = e - s;
        // start is never below the clip edge, so it fits 16 bits unsigned
        lo   = s[15:0];
        len  = (e > s) ? diff[15:0] : 16'd0;
    end

endmodule

[rtl/core/csrf_stack.sv]
`timescale 1ns / 1ps
// Clip stack: level counter, cached top clip and the store of levels 2 and up.
// Depends on csrf_pkg.
module csrf_stack
    import csrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [1:0]   op,
    input  clip_t        cut_clip,
    input  cfg_t         cfg,
    output clip_t        cur_top,
    output stack_after_t after
);

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    clip_t              top_reg;
    clip_t              top_next;
    clip_t              store_reg [SLOTS];
    clip_t              screen;
    logic [LEVEL_W-1:0] push_pos;
    logic [LEVEL_W-1:0] pop_pos;
    logic [SLOT_W-1:0]  push_slot;
    logic [SLOT_W-1:0]  pop_slot;
    logic               at_base;
    logic               full;
    logic               do_push;
    logic               ignored;

    always_comb
    begin
        screen    = '{x: 16'd0, y: 16'd0, w: cfg.screen_width, h: cfg.screen_height};
        at_base   = (level_reg == LEVEL_W'(1));
        full      = (level_reg == LEVEL_W'(STACK_DEPTH));
        push_pos  = level_reg - LEVEL_W'(1);
        pop_pos   = level_reg - LEVEL_W'(3);
        push_slot = push_pos[SLOT_W-1:0];
        pop_slot  = pop_pos[SLOT_W-1:0];
        cur_top   = at_base ? screen : top_reg;

        level_next = level_reg;
        top_next   = top_reg;
        do_push    = 1'b0;
        ignored    = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (full)
                    ignored = 1'b1;
                else
                begin
                    do_push    = 1'b1;
                    top_next   = cut_clip;
                    level_next = level_reg + LEVEL_W'(1);
                end
            end
            OP_POP:
            begin
                if (at_base)
                    ignored = 1'b1;
                else
                begin
                    level_next = level_reg - LEVEL_W'(1);
                    // when the level below is the base, the screen replaces the value read here
                    top_next   = store_reg[pop_slot];
                end
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase

        after.top     = (level_next == LEVEL_W'(1)) ? screen : top_next;
        after.level   = level_next;
        after.ignored = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= LEVEL_W'(1);
        else if (step)
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            top_reg <= top_next;
        if (step && do_push)
            store_reg[push_slot] <= cut_clip;
    end

endmodule

[sim/clip_stack_rect_fill_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for clip_stack_rect_fill: a directed table, then random
// push, pop and fill traffic over several screen settings, checked by a predictor.
// Depends on csrf_pkg and the clip_stack_rect_fill RTL only.
module clip_stack_rect_fill_tb;
    import csrf_pkg::*;

    // One line of the directed table. When typed is set, want holds the result
    // read straight off the spec; otherwise the predictor supplies it.
    typedef struct packed {
        logic typed;
        cmd_t req;
        rsp_t want;
    } step_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    cmd_t                   cmd = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;

    // Tag that travels with the request currently on the bus.
    logic row_typed = 1'b0;
    rsp_t row_want = '0;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int settings_used = 1;
    int peak_level = 1;
    int refused_seen = 0;
    int fills_drawn = 0;

    // Predictor state: live copy of the registers and of the clip stack.
    cfg_t  screen_cfg;
    clip_t clip_levels [SLOTS];
    int    model_level;

    rsp_t      pending_results [$];
    step_row_t directed_rows [$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    clip_stack_rect_fill u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Receiver back-pressure: redraw the stall every falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic cmd_t draw_request(input logic [1:0] op, input int x, input int y,
                                          input int w, input int h,
                                          input logic [31:0] colour);
        cmd_t c;
        c.op          = op;
        c.rect_x      = x[15:0];
        c.rect_y      = y[15:0];
        c.rect_width  = w[15:0];
        c.rect_height = h[15:0];
        c.fill_colour = colour;
        return c;
    endfunction

    function automatic rsp_t clip_result(input int x, input int y, input int w, input int h,
                                         input int level, input logic refused,
                                         input logic present, input logic [31:0] addr,
                                         input int cols, input int rows,
                                         input logic [31:0] value);
        rsp_t r;
        r.top_x        = x[15:0];
        r.top_y        = y[15:0];
        r.top_width    = w[15:0];
        r.top_height   = h[15:0];
        r.stack_level  = level[LEVEL_W-1:0];
        r.ignored      = refused;
        r.fill_present = present;
        r.fill_address = addr;
        r.fill_columns = cols[15:0];
        r.fill_rows    = rows[15:0];
        r.fill_value   = value;
        return r;
    endfunction

    // Base level is the whole screen, read live from the registers.
    function automatic clip_t top_clip_now();
        clip_t c;
        if (model_level <= 1)
        begin
            c.x = '0;
            c.y = '0;
            c.w = screen_cfg.screen_width;
            c.h = screen_cfg.screen_height;
        end
        else
            c = clip_levels[model_level - 2];
        return c;
    endfunction

    // Intersect one axis: span [start, start+len) against [edge0, edge0+len0).
    function automatic void overlap_axis(input longint start, input longint len,
                                         input longint edge0, input longint len0,
                                         output longint cut_lo, output longint cut_len);
        longint far_a;
        longint far_b;
        longint far_end;
        cut_lo  = (start > edge0) ? start : edge0;
        far_a   = start + len;
        far_b   = edge0 + len0;
        far_end = (far_a < far_b) ? far_a : far_b;
        cut_len = (far_end > cut_lo) ? far_end - cut_lo : 0;
    endfunction

    // Advance the clip stack by one request and return the result it must give.
    function automatic rsp_t clip_engine_step(input cmd_t c);
        clip_t  top;
        longint nx, ny, nw, nh;
        longint stride;
        rsp_t   r;
        r   = '0;
        top = top_clip_now();
        overlap_axis(longint'($signed(c.rect_x)), longint'(c.rect_width),
                     longint'(top.x), longint'(top.w), nx, nw);
        overlap_axis(longint'($signed(c.rect_y)), longint'(c.rect_height),
                     longint'(top.y), longint'(top.h), ny, nh);
        case (c.op)
            OP_PUSH:
                if (model_level >= STACK_DEPTH)
                    r.ignored = 1'b1;
                else
                begin
                    clip_levels[model_level - 1].x = nx[15:0];
                    clip_levels[model_level - 1].y = ny[15:0];
                    clip_levels[model_level - 1].w = nw[15:0];
                    clip_levels[model_level - 1].h = nh[15:0];
                    model_level++;
                end
            OP_POP:
                if (model_level <= 1)
                    r.ignored = 1'b1;
                else
                    model_level--;
            OP_FILL:
                if (nw > 0 && nh > 0)
                begin
                    stride         = longint'(screen_cfg.row_pitch_bytes >> 2);
                    r.fill_present = 1'b1;
                    r.fill_address = 32'(longint'(screen_cfg.frame_base) + ny * stride + nx);
                    r.fill_columns = nw[15:0];
                    r.fill_rows    = nh[15:0];
                    r.fill_value   = c.fill_colour;
                end
            default:
                ;
        endcase
        top           = top_clip_now();
        r.top_x       = top.x;
        r.top_y       = top.y;
        r.top_width   = top.w;
        r.top_height  = top.h;
        r.stack_level = model_level[LEVEL_W-1:0];
        return r;
    endfunction

    function automatic void match_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_result(input rsp_t want, input rsp_t got);
        match_field("top_x", 64'(want.top_x), 64'(got.top_x));
        match_field("top_y", 64'(want.top_y), 64'(got.top_y));
        match_field("top_width", 64'(want.top_width), 64'(got.top_width));
        match_field("top_height", 64'(want.top_height), 64'(got.top_height));
        match_field("stack_level", 64'(want.stack_level), 64'(got.stack_level));
        match_field("ignored", 64'(want.ignored), 64'(got.ignored));
        match_field("fill_present", 64'(want.fill_present), 64'(got.fill_present));
        match_field("fill_address", 64'(want.fill_address), 64'(got.fill_address));
        match_field("fill_columns", 64'(want.fill_columns), 64'(got.fill_columns));
        match_field("fill_rows", 64'(want.fill_rows), 64'(got.fill_rows));
        match_field("fill_value", 64'(want.fill_value), 64'(got.fill_value));
    endfunction

    // Scoreboard: check the result first, since a request taken at this edge
    // cannot have produced it; then predict the request taken at this edge.
    always @(posedge clk)
    begin : watch
        rsp_t want;
        rsp_t model;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_result(want, rsp);
                    results_checked++;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                model = clip_engine_step(cmd);
                pending_results.push_back(row_typed ? row_want : model);
                requests_sent++;
                refused_seen += int'(model.ignored);
                fills_drawn  += int'(model.fill_present);
                if (int'(model.stack_level) > peak_level)
                    peak_level = int'(model.stack_level);
            end
        end
    end

    // Present one request at a falling edge, with a random gap in front, and
    // hold it until the block takes it. Return at the falling edge after that.
    task automatic send_request(input cmd_t req, input logic typed, input rsp_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= req;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding result, plus the pipeline depth.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write one register and mirror it, keeping only the bits the register holds.
    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SCREEN_WIDTH:  screen_cfg.screen_width    = data[15:0];
            REG_SCREEN_HEIGHT: screen_cfg.screen_height   = data[15:0];
            REG_ROW_PITCH:     screen_cfg.row_pitch_bytes = data[17:0];
            REG_FRAME_BASE:    screen_cfg.frame_base      = data[29:0];
            default:           ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_screen(input logic [CFG_DATA_W-1:0] wide,
                                input logic [CFG_DATA_W-1:0] tall,
                                input logic [CFG_DATA_W-1:0] pitch,
                                input logic [CFG_DATA_W-1:0] base);
        drain_results();
        write_reg(REG_SCREEN_WIDTH, wide);
        write_reg(REG_SCREEN_HEIGHT, tall);
        write_reg(REG_ROW_PITCH, pitch);
        write_reg(REG_FRAME_BASE, base);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Random request, sized around the current screen so clipping bites on
    // both sides; one in ten uses fully random fields.
    function automatic cmd_t random_request(input int push_pct, input int pop_pct);
        cmd_t c;
        int   pick;
        int   span_x;
        int   span_y;
        pick = $urandom_range(99);
        if (pick < push_pct)
            c.op = OP_PUSH;
        else if (pick < push_pct + pop_pct)
            c.op = OP_POP;
        else if (pick < 95)
            c.op = OP_FILL;
        else
            c.op = OP_NOP;
        c.fill_colour = $urandom;
        if ($urandom_range(9) == 0)
        begin
            c.rect_x      = 16'($urandom);
            c.rect_y      = 16'($urandom);
            c.rect_width  = 16'($urandom);
            c.rect_height = 16'($urandom);
        end
        else
        begin
            span_x        = int'(screen_cfg.screen_width);
            span_y        = int'(screen_cfg.screen_height);
            c.rect_x      = 16'(int'($urandom_range(span_x + 64)) - 64);
            c.rect_y      = 16'(int'($urandom_range(span_y + 64)) - 64);
            c.rect_width  = 16'($urandom_range(span_x / 2 + 16));
            c.rect_height = 16'($urandom_range(span_y / 2 + 16));
        end
        return c;
    endfunction

    initial
    begin : stimulus
        step_row_t row;
        int        k;
        int        phase;
        int        push_pct;
        int        pop_pct;

        // Register defaults and an empty stack, as after reset.
        screen_cfg.screen_width    = 16'd640;
        screen_cfg.screen_height   = 16'd480;
        screen_cfg.row_pitch_bytes = 18'd2560;
        screen_cfg.frame_base      = 30'd0;
        model_level                = 1;

        // Refuse a pop at the base; fill the whole screen.
        directed_rows.push_back('{1'b1, draw_request(OP_POP, 0, 0, 0, 0, 0),
            clip_result(0, 0, 640, 480, 1, 1'b1, 1'b0, 0, 0, 0, 0)});
        directed_rows.push_back('{1'b1, draw_request(OP_FILL, 0, 0, 640, 480, 32'hFFFF_FFFF),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b1, 0, 640, 480, 32'hFFFF_FFFF)});
        // Most negative corner with the widest span: clipped to the screen.
        directed_rows.push_back('{1'b1,
            draw_request(OP_FILL, -32768, -32768, 65535, 65535, 32'h0),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b1, 0, 640, 480, 32'h0)});
        // Far corner off screen, then a zero width: both empty.
        directed_rows.push_back('{1'b1,
            draw_request(OP_FILL, 32767, 32767, 65535, 65535, 32'h5A5A_5A5A),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b0, 0, 0, 0, 0)});
        directed_rows.push_back('{1'b1, draw_request(OP_FILL, 10, 10, 0, 20, 32'hA5A5_A5A5),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b0, 0, 0, 0, 0)});
        // No operation with every field bit set changes nothing.
        directed_rows.push_back('{1'b1,
            draw_request(OP_NOP, -1, -1, 65535, 65535, 32'hFFFF_FFFF),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b0, 0, 0, 0, 0)});
        // Last pixel of the screen: row 479 times stride 640 plus column 639.
        directed_rows.push_back('{1'b1, draw_request(OP_FILL, 639, 479, 1, 1, 32'h1234_5678),
            clip_result(0, 0, 640, 480, 1, 1'b0, 1'b1, 32'd307199, 1, 1, 32'h1234_5678)});
        directed_rows.push_back('{1'b1, draw_request(OP_PUSH, 100, 50, 200, 100, 32'h0),
            clip_result(100, 50, 200, 100, 2, 1'b0, 1'b0, 0, 0, 0, 0)});
        // Widest push collapses to the current clip; a zero-width clip empties fills.
        directed_rows.push_back('{1'b0,
            draw_request(OP_PUSH, -32768, -32768, 65535, 65535, 32'h0), rsp_t'(0)});
        directed_rows.push_back('{1'b0, draw_request(OP_PUSH, 150, 80, 0, 10, 32'h0),
            rsp_t'(0)});
        directed_rows.push_back('{1'b0, draw_request(OP_FILL, 0, 0, 640, 480, 32'hC0FF_EE00),
            rsp_t'(0)});
        directed_rows.push_back('{1'b0, draw_request(OP_POP, 0, 0, 0, 0, 32'h0), rsp_t'(0)});
        // Nest shrinking clips until the stack is full.
        for (k = 0; k < 13; k++)
            directed_rows.push_back('{1'b0,
                draw_request(OP_PUSH, 100 + k, 50 + k, 200 - 2 * k, 100 - 2 * k, k),
                rsp_t'(0)});
        // Push on a full stack is refused and leaves the innermost clip on top.
        directed_rows.push_back('{1'b1, draw_request(OP_PUSH, 0, 0, 10, 10, 32'h0),
            clip_result(112, 62, 176, 76, 16, 1'b1, 1'b0, 0, 0, 0, 0)});

        send_gap_pct   = 25;
        recv_stall_pct = 53;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.req, row.typed, row.want);
        end

        // Random part: three idling regimes, each over four screen settings
        // (a mid-size screen, every register at its top value, every register
        // at zero, and a tiny screen written with junk in the unused bits).
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase / 4)
                0:
                begin
                    send_gap_pct   = 25;
                    recv_stall_pct = 53;
                end
                1:
                begin
                    send_gap_pct   = 53;
                    recv_stall_pct = 25;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (phase % 4)
                0: apply_screen(30'($urandom_range(2000, 1)), 30'($urandom_range(1200, 1)),
                                30'($urandom_range(8192)), 30'($urandom));
                1: apply_screen('1, '1, '1, '1);
                2: apply_screen('0, '0, '0, '0);
                default: apply_screen({14'($urandom), 16'($urandom_range(64, 1))},
                                      {14'($urandom), 16'($urandom_range(64, 1))},
                                      30'($urandom), 30'($urandom));
            endcase
            // Alternate a climbing stack with a shrinking one so both the full
            // stack and the bare base get hit in every regime.
            push_pct = (phase % 2 == 1) ? 45 : 20;
            pop_pct  = (phase % 2 == 1) ? 15 : 40;
            for (k = 0; k < 96; k++)
            begin
                if ($urandom_range(199) == 0)
                    drain_results();
                send_request(random_request(push_pct, pop_pct), 1'b0, rsp_t'(0));
            end
        end

        drain_results();
        $display("Sent %0d push/pop/fill requests over %0d screen settings;",
                 requests_sent, settings_used);
        $display("%0d results compared, deepest stack %0d, %0d refused pushes or pops,",
                 results_checked, peak_level, refused_seen);
        $display("%0d non-empty fills, %0d mismatches.", fills_drawn, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
